/* src/exhaust_request_lead_lag_fsm_core_assert.svh */
// Assertion helpers for the exhaust lead/lag block.
// Each macro samples on the rising edge of clock and is muted during reset.
`ifndef EXHAUST_REQUEST_LEAD_LAG_FSM_CORE_ASSERT_SVH
`define EXHAUST_REQUEST_LEAD_LAG_FSM_CORE_ASSERT_SVH

// Same-cycle implication
`define ERLL_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("exhaust lead/lag check failed");

// Next-cycle implication
`define ERLL_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("exhaust lead/lag check failed");

`endif

/* src/erll_pkg.sv */
package erll_pkg;

   // Field widths
   localparam int LEAD_W      = 18;
   localparam int LAG_W       = 24;
   localparam int INDEX_W     = 4;
   localparam int STAGE_W     = 3;
   localparam int PHASE_W     = 2;
   localparam int DIVIDEND_W  = 32;
   localparam int PERIOD_W    = 21;
   localparam int CNT_W       = $clog2(DIVIDEND_W);
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam int MS_PER_MINUTE = 60000;
   localparam int PATTERN_COUNT = 10;

   // Encoded phase as seen on the result channel
   localparam logic [PHASE_W-1:0] PHASE_IDLE_CODE   = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_LEAD_CODE   = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_ACTIVE_CODE = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_LAG_CODE    = 2'd3;

   // Phase machine
   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_LEAD   = 4'b0010,
      PH_ACTIVE = 4'b0100,
      PH_LAG    = 4'b1000
   } phase_type;

   // Item sequencer
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_HOLD = 3'b100
   } seq_type;

   // Register map, word index
   typedef enum logic [2:0] {
      REG_LEAD_TIME  = 3'd0,
      REG_LAG_TIME   = 3'd1,
      REG_INTERMIT   = 3'd2,
      REG_STAGE      = 3'd3,
      REG_SUPPLY_ENA = 3'd4
   } reg_index_type;

   // Status of the modulo unit
   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

   function automatic logic [PHASE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_W-1:0] code;
      case (ph)
         PH_IDLE:   code = PHASE_IDLE_CODE;
         PH_LEAD:   code = PHASE_LEAD_CODE;
         PH_ACTIVE: code = PHASE_ACTIVE_CODE;
         PH_LAG:    code = PHASE_LAG_CODE;
         default:   code = PHASE_IDLE_CODE;
      endcase
      return code;
   endfunction

   function automatic logic pattern_valid(input logic [INDEX_W-1:0] idx);
      return (idx != '0) && (idx < INDEX_W'(PATTERN_COUNT));
   endfunction

   // Period of the intermittent pattern in ms
   function automatic logic [PERIOD_W-1:0] pattern_period_ms(input logic [INDEX_W-1:0] idx);
      logic [PERIOD_W-1:0] val;
      case (idx)
         4'd1, 4'd2:             val = PERIOD_W'(5 * MS_PER_MINUTE);
         4'd3, 4'd4, 4'd5:       val = PERIOD_W'(15 * MS_PER_MINUTE);
         4'd6, 4'd7, 4'd8, 4'd9: val = PERIOD_W'(30 * MS_PER_MINUTE);
         default:                val = '0;
      endcase
      return val;
   endfunction

   // On time within each period in ms
   function automatic logic [PERIOD_W-1:0] pattern_on_ms(input logic [INDEX_W-1:0] idx);
      logic [PERIOD_W-1:0] val;
      case (idx)
         4'd1, 4'd3, 4'd6: val = PERIOD_W'(1 * MS_PER_MINUTE);
         4'd2, 4'd4, 4'd7: val = PERIOD_W'(2 * MS_PER_MINUTE);
         4'd5, 4'd8:       val = PERIOD_W'(5 * MS_PER_MINUTE);
         4'd9:             val = PERIOD_W'(10 * MS_PER_MINUTE);
         default:          val = '0;
      endcase
      return val;
   endfunction

endpackage

/* src/erll_if.sv */
// Tick channel
interface erll_req_if import erll_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  request;
   logic [DIVIDEND_W-1:0] now_ms;

   modport source (output valid, output request, output now_ms, input ready);
   modport sink   (input valid, input request, input now_ms, output ready);
endinterface

// Result channel
interface erll_rsp_if import erll_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               demand_active;
   logic [STAGE_W-1:0] demand_stage;
   logic               supply_request;
   logic [PHASE_W-1:0] phase;

   modport source (output valid, output demand_active, output demand_stage,
                   output supply_request, output phase, input ready);
   modport sink   (input valid, input demand_active, input demand_stage,
                   input supply_request, input phase, output ready);
endinterface

/* src/exhaust_request_lead_lag_fsm_core.sv */
// Channel   Dir  Port     Beat contents
// tick      in   req_bus  request, now_ms
// result    out  rsp_bus  demand_active, demand_stage, supply_request, phase
// config    in   APB      lead, lag, pattern index, stage, supply enable
//
// One tick at a time. With an intermittent pattern in active or lag, a tick passes
// from accept through the 32-step serial modulo unit and ST_HOLD to the output register.
// Any other tick goes from accept through ST_HOLD into the output register.
// A new tick is taken once the previous result sits in the output register.
// Reset is synchronous: phase goes to idle, configuration registers to zero.
// A stalled result holds in the output register; the next tick waits behind it.
`include "exhaust_request_lead_lag_fsm_core_assert.svh"

module exhaust_request_lead_lag_fsm_core import erll_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   erll_req_if.sink              req_bus,
   erll_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Configuration registers
   logic [LEAD_W-1:0]  lead_ff;
   logic [LAG_W-1:0]   lag_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [STAGE_W-1:0] stage_ff;
   logic               supply_ena_ff;

   // Phase state
   phase_type             phase_ff, phase_in;
   logic [DIVIDEND_W-1:0] since_ff, since_in;

   // Sequencer
   seq_type            seq_ff, seq_in;
   logic               demand_ff, demand_in;
   logic [PERIOD_W-1:0] on_ff, on_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_demand_ff, rsp_demand_in;
   logic               rsp_supply_ff, rsp_supply_in;
   logic [STAGE_W-1:0] rsp_stage_ff, rsp_stage_in;
   logic [PHASE_W-1:0] rsp_phase_ff, rsp_phase_in;

   logic                  accept;
   logic                  slot_free;
   logic                  csr_write;
   reg_index_type         csr_index;
   logic [DIVIDEND_W-1:0] elapsed;
   phase_type             phase_nx;
   logic                  since_upd;
   logic                  running;
   logic                  use_pattern;
   logic                  mod_start;
   logic [DIVIDEND_W-1:0] mod_dividend;
   logic [PERIOD_W-1:0]   mod_rem;
   mod_stat_type          mod_stat;

   assign accept    = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (seq_ff == ST_IDLE);

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      case (csr_index)
         REG_LEAD_TIME:  prdata = CSR_DATA_W'(lead_ff);
         REG_LAG_TIME:   prdata = CSR_DATA_W'(lag_ff);
         REG_INTERMIT:   prdata = CSR_DATA_W'(index_ff);
         REG_STAGE:      prdata = CSR_DATA_W'(stage_ff);
         REG_SUPPLY_ENA: prdata = CSR_DATA_W'(supply_ena_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff       <= '0;
         lag_ff        <= '0;
         index_ff      <= '0;
         stage_ff      <= '0;
         supply_ena_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_LEAD_TIME:  lead_ff       <= pwdata[LEAD_W-1:0];
            REG_LAG_TIME:   lag_ff        <= pwdata[LAG_W-1:0];
            REG_INTERMIT:   index_ff      <= pwdata[INDEX_W-1:0];
            REG_STAGE:      stage_ff      <= pwdata[STAGE_W-1:0];
            REG_SUPPLY_ENA: supply_ena_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Phase transition for the tick on the input
   assign elapsed = req_bus.now_ms - since_ff;

   always_comb begin
      phase_nx  = phase_ff;
      since_upd = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (req_bus.request) begin
               phase_nx  = (lead_ff != '0) ? PH_LEAD : PH_ACTIVE;
               since_upd = 1'b1;
            end
         end
         PH_LEAD: begin
            if (!req_bus.request) begin
               phase_nx = PH_IDLE;
            end else if (elapsed >= DIVIDEND_W'(lead_ff)) begin
               phase_nx  = PH_ACTIVE;
               since_upd = 1'b1;
            end
         end
         PH_ACTIVE: begin
            if (!req_bus.request) begin
               phase_nx  = (lag_ff != '0) ? PH_LAG : PH_IDLE;
               since_upd = 1'b1;
            end
         end
         PH_LAG: begin
            if (req_bus.request) begin
               phase_nx  = PH_ACTIVE;
               since_upd = 1'b1;
            end else if (elapsed >= DIVIDEND_W'(lag_ff)) begin
               phase_nx = PH_IDLE;
            end
         end
         default: begin
            phase_nx = PH_IDLE;
         end
      endcase
   end

   assign running      = (phase_nx == PH_ACTIVE) || (phase_nx == PH_LAG);
   assign use_pattern  = running && pattern_valid(index_ff);
   assign mod_start    = accept && use_pattern;
   // A fresh phase entry restarts the pattern at zero
   assign mod_dividend = since_upd ? '0 : elapsed;

   erll_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (pattern_period_ms(index_ff)),
      .remainder (mod_rem),
      .stat      (mod_stat)
   );

   // Sequencer: take the tick, wait on the modulo unit, hand the beat out
   always_comb begin
      seq_in        = seq_ff;
      phase_in      = phase_ff;
      since_in      = since_ff;
      demand_in     = demand_ff;
      on_in         = on_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_demand_in = rsp_demand_ff;
      rsp_supply_in = rsp_supply_ff;
      rsp_stage_in  = rsp_stage_ff;
      rsp_phase_in  = rsp_phase_ff;
      case (seq_ff)
         ST_IDLE: begin
            if (accept) begin
               phase_in  = phase_nx;
               since_in  = since_upd ? req_bus.now_ms : since_ff;
               demand_in = running;
               on_in     = pattern_on_ms(index_ff);
               seq_in    = use_pattern ? ST_CALC : ST_HOLD;
            end
         end
         ST_CALC: begin
            if (mod_stat.done) begin
               demand_in = (mod_rem < on_ff);
               seq_in    = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_demand_in = demand_ff;
               rsp_supply_in = demand_ff && supply_ena_ff;
               rsp_stage_in  = stage_ff;
               rsp_phase_in  = phase_code(phase_ff);
               seq_in        = ST_IDLE;
            end
         end
         default: begin
            seq_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      demand_ff     <= demand_in;
      on_ff         <= on_in;
      rsp_demand_ff <= rsp_demand_in;
      rsp_supply_ff <= rsp_supply_in;
      rsp_stage_ff  <= rsp_stage_in;
      rsp_phase_ff  <= rsp_phase_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.demand_active  = rsp_demand_ff;
   assign rsp_bus.supply_request = rsp_supply_ff;
   assign rsp_bus.demand_stage   = rsp_stage_ff;
   assign rsp_bus.phase          = rsp_phase_ff;

   // Checks
   `ERLL_ASSERT_IMP(a_ready_unit_quiet, req_bus.ready, !mod_stat.busy && !mod_stat.done)
   `ERLL_ASSERT_NXT(a_pattern_starts_unit, mod_start, mod_stat.busy && seq_ff == ST_CALC)
   `ERLL_ASSERT_NXT(a_done_to_hold, mod_stat.done, seq_ff == ST_HOLD)
   `ERLL_ASSERT_IMP(a_no_demand_when_off,
      rsp_bus.valid && (rsp_bus.phase == PHASE_IDLE_CODE || rsp_bus.phase == PHASE_LEAD_CODE),
      !rsp_bus.demand_active && !rsp_bus.supply_request)

endmodule

/* src/erll_mod.sv */
// Bit-serial restoring modulo: one dividend bit per cycle
module erll_mod import erll_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [PERIOD_W-1:0]   divisor,
   output logic [PERIOD_W-1:0]   remainder,
   output mod_stat_type          stat
);

   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [PERIOD_W-1:0]   div_ff, div_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [PERIOD_W:0]     trial;
   logic [PERIOD_W:0]     diff;
   logic                  fits;

   // Shift in the next dividend bit and try one subtract
   assign trial = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         rem_in = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         // Last dividend bit: drop busy, flag the remainder
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign remainder = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
